@@ design/register_machine_execute_unit_defines.svh @@
// assertion helpers for the register machine execute unit
// every macro expects a clock named clk in scope, RMEU_ASSERT also rst
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define RMEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define RMEU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/rmeu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared types and codes of the register machine execute unit: payload
// structs, opcodes, error codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rmeu_pkg;

  // opcodes
  localparam logic [3:0] OP_SET_IMM   = 4'd0;
  localparam logic [3:0] OP_COPY      = 4'd1;
  localparam logic [3:0] OP_ADD       = 4'd2;
  localparam logic [3:0] OP_SUB       = 4'd3;
  localparam logic [3:0] OP_MUL       = 4'd4;
  localparam logic [3:0] OP_DIV       = 4'd5;
  localparam logic [3:0] OP_MOD       = 4'd6;
  localparam logic [3:0] OP_SKIP_POS  = 4'd7;
  localparam logic [3:0] OP_SKIP_ZERO = 4'd8;
  localparam logic [3:0] OP_PRINT     = 4'd9;
  localparam logic [3:0] OP_HALT_EQ   = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OPCODE   = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

  // one decoded instruction
  typedef struct packed {
    logic [3:0]         opcode;
    logic [3:0]         dest_index;
    logic [3:0]         src_index;
    logic signed [31:0] immediate;
  } in_t;

  // one execution result
  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halt;
    logic               print_valid;
    logic [30:0]        print_indent;
    logic signed [31:0] print_value;
    logic [1:0]         error;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_load;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_go;
    logic div_done;
  } stat_t;

endpackage

@@ design/rmeu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeu_div
// Iterative signed 32-bit divider, one quotient bit per cycle on the
// magnitudes, C-style truncation; quotient and remainder signs fixed at the end.
// ----------------------------------------------------------------------------
module rmeu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  // one restoring step
  always_comb begin
    rem_sh = {rem, quo[31]};
    diff   = rem_sh - {1'b0, dsr};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
      dsr   <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem   <= '0;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  // sign correction
  assign quotient  = neg_q ? (32'd0 - quo) : quo;
  assign remainder = neg_r ? (32'd0 - rem) : rem;

endmodule

@@ design/rmeu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeu_datapath
// Variable file, program counter, ALU, divider and the result registers of
// the register machine execute unit, driven by the controller's commands.
// ----------------------------------------------------------------------------
module rmeu_datapath #(
  parameter int NUM_VARS = 16,
  parameter int PC_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  rmeu_pkg::cmd_t cmd,
  output rmeu_pkg::stat_t stat,
  input  rmeu_pkg::in_t  in_data,
  output rmeu_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(NUM_VARS);

  // fold a raw index into the file by repeated subtraction
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [3:0] raw);
    logic [8:0] v;
    v = {5'd0, raw};
    for (int k = 0; k < 8; k++) begin
      if (v >= 9'(NUM_VARS)) begin
        v = v - 9'(NUM_VARS);
      end
    end
    return v[IDX_W-1:0];
  endfunction

  // captured instruction
  logic [3:0]          op;
  logic [IDX_W-1:0]    di;
  logic [IDX_W-1:0]    si;
  logic [31:0]         imm;

  // variable file with per-entry valid bits
  logic [31:0]         mem [NUM_VARS];
  logic [NUM_VARS-1:0] vld;
  logic [31:0]         rd_a;
  logic [31:0]         rd_b;
  logic                va;
  logic                vb;

  logic [PC_WIDTH-1:0] pc;

  // pending result
  logic                pend_wr;
  logic [31:0]         pend_data;
  logic [PC_WIDTH-1:0] pend_pc;
  rmeu_pkg::out_t      pend_out;

  // execute stage signals
  logic [31:0]         a;
  logic [31:0]         b;
  logic [31:0]         prod;
  logic [PC_WIDTH-1:0] pc_inc;
  logic [PC_WIDTH-1:0] pc_skip;
  logic [PC_WIDTH-1:0] nxt;
  logic                wr;
  logic [31:0]         wdata;
  logic                halt;
  logic                pv;
  logic [30:0]         pind;
  logic [31:0]         pval;
  logic [1:0]          err;
  logic [31:0]         pc_wide;

  logic                div_done;
  logic [31:0]         quotient;
  logic [31:0]         remainder;

  // instruction capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= in_data.opcode;
      di  <= wrap_idx(in_data.dest_index);
      si  <= wrap_idx(in_data.src_index);
      imm <= in_data.immediate;
    end
  end

  // registered reads of both operands
  always_ff @(posedge clk) begin
    rd_a <= mem[di];
    rd_b <= mem[si];
    va   <= vld[di];
    vb   <= vld[si];
  end

  // memory write on commit
  always_ff @(posedge clk) begin
    if (cmd.commit && pend_wr) begin
      mem[di] <= pend_data;
    end
  end

  // valid bits and program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      pc  <= '0;
    end else if (cmd.commit) begin
      if (pend_wr) begin
        vld[di] <= 1'b1;
      end
      pc <= pend_pc;
    end
  end

  // alu and next pc
  always_comb begin
    a       = va ? rd_a : 32'd0;
    b       = vb ? rd_b : 32'd0;
    prod    = a * b;
    pc_inc  = pc + PC_WIDTH'(1);
    pc_skip = pc + imm[PC_WIDTH-1:0] + PC_WIDTH'(1);
    nxt     = pc_inc;
    wr      = 1'b0;
    wdata   = a;
    halt    = 1'b0;
    pv      = 1'b0;
    pind    = '0;
    pval    = '0;
    err     = rmeu_pkg::ERR_NONE;
    unique case (op) inside
      rmeu_pkg::OP_SET_IMM: begin
        wr    = 1'b1;
        wdata = imm;
      end
      rmeu_pkg::OP_COPY: begin
        wr    = 1'b1;
        wdata = b;
      end
      rmeu_pkg::OP_ADD: begin
        wr    = 1'b1;
        wdata = a + b;
      end
      rmeu_pkg::OP_SUB: begin
        wr    = 1'b1;
        wdata = a - b;
      end
      rmeu_pkg::OP_MUL: begin
        wr    = 1'b1;
        wdata = prod;
      end
      rmeu_pkg::OP_DIV, rmeu_pkg::OP_MOD: begin
        // divider result replaces the pending data later
        if (b == 32'd0) begin
          err = rmeu_pkg::ERR_DIV_ZERO;
        end else begin
          wr = 1'b1;
        end
      end
      rmeu_pkg::OP_SKIP_POS: begin
        if (!a[31] && (a != 32'd0)) begin
          nxt = pc_skip;
        end
      end
      rmeu_pkg::OP_SKIP_ZERO: begin
        if (a == 32'd0) begin
          nxt = pc_skip;
        end
      end
      rmeu_pkg::OP_PRINT: begin
        pv   = 1'b1;
        pind = a[31] ? 31'd0 : a[30:0];
        pval = b;
      end
      rmeu_pkg::OP_HALT_EQ: begin
        if (a == b) begin
          halt = 1'b1;
          nxt  = pc;
        end
      end
      default: begin
        err = rmeu_pkg::ERR_OPCODE;
      end
    endcase
    pc_wide = 32'(nxt);
  end

  assign stat.div_go   = ((op == rmeu_pkg::OP_DIV) || (op == rmeu_pkg::OP_MOD)) &&
                         (b != 32'd0);
  assign stat.div_done = div_done;

  // pending result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_wr                <= wr;
      pend_data              <= wdata;
      pend_pc                <= nxt;
      pend_out.next_pc       <= pc_wide[15:0];
      pend_out.halt          <= halt;
      pend_out.print_valid   <= pv;
      pend_out.print_indent  <= pind;
      pend_out.print_value   <= pval;
      pend_out.error         <= err;
    end else if (cmd.div_load) begin
      pend_data <= (op == rmeu_pkg::OP_DIV) ? quotient : remainder;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= pend_out;
    end
  end

  rmeu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (a),
    .divisor   (b),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

endmodule

@@ design/rmeu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeu_ctrl
// Sequencer of the register machine execute unit, owning the output valid
// flag: read, execute, divide for div/mod by nonzero, commit, per instruction.
// ----------------------------------------------------------------------------
`include "register_machine_execute_unit_defines.svh"

module rmeu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rmeu_pkg::stat_t stat,
  output rmeu_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // commands to the datapath
  assign cmd.capture   = (state == S_IDLE) && in_valid;
  assign cmd.exec      = (state == S_EXEC);
  assign cmd.div_start = (state == S_EXEC) && stat.div_go;
  assign cmd.div_load  = (state == S_DIV) && stat.div_done;
  assign cmd.commit    = (state == S_COMMIT) && out_free;

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= stat.div_go ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `RMEU_ASSERT(a_commit_slot, cmd.commit |-> (!out_valid || out_ready), "output register full")
  `RMEU_ASSERT(a_commit_shows, cmd.commit |=> out_valid, "committed result not presented")
  `RMEU_ASSERT(a_accept_busy, cmd.capture |=> !in_ready, "second transaction while busy")
  `RMEU_ASSERT(a_div_done_state, stat.div_done |-> (state == S_DIV), "early divider done")

endmodule

@@ design/register_machine_execute_unit.sv @@
`timescale 1ns / 1ps
// an accepted instruction is read, executed and committed; divide and modulo with a nonzero
// divisor run the iterative divider between execute and commit, one quotient bit per cycle
// commit waits for a free output register, and no new instruction is taken until it commits
// reset: synchronous; program counter returns to zero and every variable reads as zero
// (per-entry valid bits clear at once, no clearing pass), output register empties
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes decoded instructions of a small register machine against a file of
// signed 32-bit variables and a program counter, one result per instruction.
// ----------------------------------------------------------------------------
module register_machine_execute_unit #(
  parameter int NUM_VARS = 16,
  parameter int PC_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmeu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rmeu_pkg::out_t out_data
);

  rmeu_pkg::cmd_t  cmd;
  rmeu_pkg::stat_t stat;

  // sequencer
  rmeu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // variable file, alu, divider and result registers
  rmeu_datapath #(
    .NUM_VARS (NUM_VARS),
    .PC_WIDTH (PC_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ test/register_machine_execute_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_execute_unit_tb
// Self-checking bench for the execute unit. It drives decoded instructions
// over a valid/ready channel and keeps its own copy of the variable file and
// program counter to predict every result. A checker compares each result
// transaction field by field with the oldest prediction. Both channels idle
// at random, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module register_machine_execute_unit_tb;

  localparam int NUM_VARS = 16;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  rmeu_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  rmeu_pkg::out_t out_data;

  // predictor state
  logic [31:0]    var_file [NUM_VARS];
  logic [15:0]    prog_ctr;
  rmeu_pkg::out_t outcome_q [$];

  int mismatch_count = 0;
  bit gaps_on = 1'b1;

  register_machine_execute_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // random idle length, mostly short with a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rmeu_pkg::in_t mk_instr(logic [3:0] op, int dst, int src,
                                             logic [31:0] imm);
    rmeu_pkg::in_t instr;
    instr.opcode     = op;
    instr.dest_index = 4'(dst);
    instr.src_index  = 4'(src);
    instr.immediate  = imm;
    return instr;
  endfunction

  // executes one instruction on the local state and returns its result
  function automatic rmeu_pkg::out_t execute_instr(rmeu_pkg::in_t instr);
    rmeu_pkg::out_t res;
    logic [31:0]    a;
    logic [31:0]    b;
    logic [31:0]    imm;
    logic [15:0]    step_pc;
    longint         sa;
    longint         sb;
    longint         quot;
    int             di;
    int             si;
    di      = instr.dest_index % NUM_VARS;
    si      = instr.src_index % NUM_VARS;
    a       = var_file[di];
    b       = var_file[si];
    imm     = instr.immediate;
    sa      = $signed(a);
    sb      = $signed(b);
    step_pc = prog_ctr + 16'd1;
    res     = '0;
    case (instr.opcode) inside
      rmeu_pkg::OP_SET_IMM: var_file[di] = imm;
      rmeu_pkg::OP_COPY:    var_file[di] = b;
      rmeu_pkg::OP_ADD:     var_file[di] = a + b;
      rmeu_pkg::OP_SUB:     var_file[di] = a - b;
      rmeu_pkg::OP_MUL:     var_file[di] = a * b;
      rmeu_pkg::OP_DIV, rmeu_pkg::OP_MOD: begin
        // zero divisor leaves the destination alone
        if (b == 32'd0) begin
          res.error = rmeu_pkg::ERR_DIV_ZERO;
        end else begin
          quot = (instr.opcode == rmeu_pkg::OP_DIV) ? (sa / sb) : (sa % sb);
          var_file[di] = quot[31:0];
        end
      end
      rmeu_pkg::OP_SKIP_POS: begin
        if (!a[31] && a != 32'd0) step_pc = prog_ctr + imm[15:0] + 16'd1;
      end
      rmeu_pkg::OP_SKIP_ZERO: begin
        if (a == 32'd0) step_pc = prog_ctr + imm[15:0] + 16'd1;
      end
      rmeu_pkg::OP_PRINT: begin
        res.print_valid  = 1'b1;
        res.print_indent = a[31] ? 31'd0 : a[30:0];
        res.print_value  = b;
      end
      rmeu_pkg::OP_HALT_EQ: begin
        if (a == b) begin
          res.halt = 1'b1;
          step_pc  = prog_ctr;
        end
      end
      default: res.error = rmeu_pkg::ERR_OPCODE;
    endcase
    prog_ctr    = step_pc;
    res.next_pc = step_pc;
    return res;
  endfunction

  // immediates: small skip distances, extremes, or anything
  function automatic logic [31:0] random_imm();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 32'($urandom_range(0, 16)) - 32'd8;
    if (roll == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return 32'd0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic rmeu_pkg::in_t random_instr();
    int         roll;
    logic [3:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 4) op = 4'($urandom_range(11, 15));
    else if (roll < 20) op = rmeu_pkg::OP_SET_IMM;
    else op = 4'($urandom_range(0, 10));
    return mk_instr(op, $urandom_range(0, 15), $urandom_range(0, 15), random_imm());
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch, got %0d, wanted %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // sends one instruction and predicts its result once accepted
  task automatic send_instr(rmeu_pkg::in_t instr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= instr;
    do @(posedge clk); while (in_ready !== 1'b1);
    outcome_q.push_back(execute_instr(instr));
  endtask

  // stops sending until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // every opcode, field extremes, wraps and the divide corner cases
  task automatic test_directed_cases();
    send_instr(mk_instr(rmeu_pkg::OP_SET_IMM, 0, 0, 32'h7fff_ffff));
    send_instr(mk_instr(rmeu_pkg::OP_SET_IMM, 1, 0, 32'h8000_0000));
    send_instr(mk_instr(rmeu_pkg::OP_SET_IMM, 2, 15, 32'hffff_ffff));
    send_instr(mk_instr(rmeu_pkg::OP_COPY, 3, 1, 32'd0));
    // min plus minus one wraps to max
    send_instr(mk_instr(rmeu_pkg::OP_ADD, 3, 2, 32'd0));
    // zero minus min wraps back to min
    send_instr(mk_instr(rmeu_pkg::OP_SUB, 15, 1, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_MUL, 0, 0, 32'd0));
    // most negative over minus one
    send_instr(mk_instr(rmeu_pkg::OP_DIV, 1, 2, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_MOD, 15, 2, 32'd0));
    // zero divisor
    send_instr(mk_instr(rmeu_pkg::OP_DIV, 3, 4, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_MOD, 3, 4, 32'd0));
    // negative dividend rounds toward zero
    send_instr(mk_instr(rmeu_pkg::OP_SET_IMM, 4, 0, -32'sd7));
    send_instr(mk_instr(rmeu_pkg::OP_SET_IMM, 5, 0, 32'd2));
    send_instr(mk_instr(rmeu_pkg::OP_MOD, 6, 5, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_COPY, 6, 4, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_DIV, 6, 5, 32'd0));
    // skips taken backwards past zero, taken forwards and not taken
    send_instr(mk_instr(rmeu_pkg::OP_SKIP_POS, 3, 0, -32'sd40));
    send_instr(mk_instr(rmeu_pkg::OP_SKIP_POS, 1, 0, 32'd5));
    send_instr(mk_instr(rmeu_pkg::OP_SKIP_ZERO, 15, 0, 32'h7fff_ffff));
    send_instr(mk_instr(rmeu_pkg::OP_SKIP_ZERO, 0, 0, 32'd3));
    // negative indent clamps, max indent passes
    send_instr(mk_instr(rmeu_pkg::OP_PRINT, 1, 3, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_PRINT, 3, 1, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_HALT_EQ, 7, 8, 32'd0));
    send_instr(mk_instr(rmeu_pkg::OP_HALT_EQ, 0, 1, 32'd0));
    send_instr(mk_instr(4'd11, 2, 3, 32'hffff_ffff));
    send_instr(mk_instr(4'd15, 15, 15, 32'd0));
  endtask

  // random program with no idling on either side
  task automatic test_back_to_back(int count);
    gaps_on = 1'b0;
    repeat (count) send_instr(random_instr());
    gaps_on = 1'b1;
  endtask

  // random program with idling on both sides, drained once midway
  task automatic test_random_program(int count);
    repeat (count / 2) send_instr(random_instr());
    wait_for_results();
    repeat (count - count / 2) send_instr(random_instr());
  endtask

  // result sink backpressure
  initial begin
    forever begin
      if (!gaps_on) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    rmeu_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unpredicted result, next_pc", out_data.next_pc, -1);
      end else begin
        want = outcome_q.pop_front();
        if (out_data.next_pc !== want.next_pc)
          report_mismatch("next_pc", out_data.next_pc, want.next_pc);
        if (out_data.halt !== want.halt)
          report_mismatch("halt", out_data.halt, want.halt);
        if (out_data.print_valid !== want.print_valid)
          report_mismatch("print_valid", out_data.print_valid, want.print_valid);
        if (out_data.print_indent !== want.print_indent)
          report_mismatch("print_indent", out_data.print_indent, want.print_indent);
        if (out_data.print_value !== want.print_value)
          report_mismatch("print_value", out_data.print_value, want.print_value);
        if (out_data.error !== want.error)
          report_mismatch("error", out_data.error, want.error);
      end
    end
  end

  // main sequence
  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    foreach (var_file[k]) var_file[k] = '0;
    prog_ctr = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    wait_for_results();
    test_back_to_back(100);
    wait_for_results();
    test_random_program(300);
    wait_for_results();

    // let any stray late result show up
    repeat (50) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch("leftover predictions", outcome_q.size(), 0);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
